### design/htok_pkg.sv
// shared types, constants and codes of the http request header tokenizer
package htok_pkg;

    // default configuration of the top level
    localparam int HEADER_LIMIT_DEF = 16;
    localparam int OFFSET_BITS_DEF  = 16;

    // result queue sizing
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
    localparam int Q_COUNT_BITS = $clog2(Q_DEPTH + 1);

    // delimiter bytes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [3:0] {
        PH_METHOD,
        PH_PATH,
        PH_VERSION,
        PH_VER_LF,
        PH_LINE,
        PH_NAME,
        PH_SKIP,
        PH_VALUE,
        PH_VAL_LF,
        PH_BLANK_LF,
        PH_BODY,
        PH_ERROR
    } htok_phase_t;

    typedef enum logic [2:0] {
        KIND_METHOD,
        KIND_PATH,
        KIND_VERSION,
        KIND_HDR_NAME,
        KIND_HDR_VALUE,
        KIND_DONE
    } htok_kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MALFORMED,
        ST_TOO_LONG
    } htok_status_t;

    typedef struct packed {
        htok_kind_t   token_kind;
        logic [15:0]  slice_offset;
        logic [15:0]  slice_length;
        logic [4:0]   header_number;
        htok_status_t parse_status;
        logic         run_last;
    } htok_result_t;

    // results produced by one byte, in output order
    typedef struct packed {
        logic [1:0]   count;
        htok_result_t first;
        htok_result_t second;
    } htok_push_t;

    // fill level of the result queue
    typedef struct packed {
        logic [Q_COUNT_BITS-1:0] count;
    } htok_qstat_t;

endpackage

### design/htok_in_if.sv
// byte input channel of the tokenizer
interface htok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

### design/htok_out_if.sv
// result output channel of the tokenizer
interface htok_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] slice_offset;
    logic [15:0] slice_length;
    logic [4:0]  header_number;
    logic [1:0]  parse_status;
    logic        run_last;

    modport source (output valid, output token_kind, output slice_offset,
                    output slice_length, output header_number, output parse_status,
                    output run_last, input ready);
    modport sink   (input valid, input token_kind, input slice_offset,
                    input slice_length, input header_number, input parse_status,
                    input run_last, output ready);
endinterface

### design/htok_core.sv
// parse state registers and the per-byte token decision logic
module htok_core #(
    parameter int HEADER_LIMIT = htok_pkg::HEADER_LIMIT_DEF,
    parameter int OFFSET_BITS  = htok_pkg::OFFSET_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    output htok_pkg::htok_push_t push
);

    localparam int HW = $clog2(HEADER_LIMIT + 1);
    localparam logic [HW-1:0] HL_W = HW'(HEADER_LIMIT);

    htok_pkg::htok_phase_t  phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] vlen_reg, vlen_next;
    logic [HW-1:0]          hseen_reg, hseen_next;
    htok_pkg::htok_status_t err_reg, err_next;

    htok_pkg::htok_phase_t  ph;
    htok_pkg::htok_phase_t  ph_new;
    logic [OFFSET_BITS-1:0] start_new;
    logic [OFFSET_BITS-1:0] vlen_new;
    logic [HW-1:0]          hseen_new;
    htok_pkg::htok_status_t err_new;
    logic                   room;
    logic                   pos_max;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic                   tok_valid;
    htok_pkg::htok_result_t tok;
    htok_pkg::htok_result_t done;

    assign room    = hseen_reg < HL_W;
    assign pos_max = (pos_reg == '1);
    assign pos_inc = pos_reg + OFFSET_BITS'(1);

    // phase transition and token emission for one byte
    always_comb
    begin
        ph        = phase_reg;
        err_new   = err_reg;
        start_new = start_reg;
        vlen_new  = vlen_reg;
        hseen_new = hseen_reg;
        tok_valid = 1'b0;
        tok.token_kind    = htok_pkg::KIND_METHOD;
        tok.slice_offset  = 16'(start_reg);
        tok.slice_length  = 16'(pos_reg - start_reg);
        tok.header_number = 5'd0;
        tok.parse_status  = htok_pkg::ST_OK;
        tok.run_last      = ~final_byte;

        // offset counter exhausted
        if (ph != htok_pkg::PH_ERROR && pos_max)
        begin
            if (err_new == htok_pkg::ST_OK)
                err_new = htok_pkg::ST_TOO_LONG;
            ph = htok_pkg::PH_ERROR;
        end
        ph_new = ph;

        case (ph)
            htok_pkg::PH_METHOD,
            htok_pkg::PH_PATH:
            begin
                if (data_byte == htok_pkg::CH_SPACE)
                begin
                    tok_valid      = 1'b1;
                    tok.token_kind = (ph == htok_pkg::PH_METHOD) ? htok_pkg::KIND_METHOD
                                                                 : htok_pkg::KIND_PATH;
                    start_new      = pos_inc;
                    ph_new         = (ph == htok_pkg::PH_METHOD) ? htok_pkg::PH_PATH
                                                                 : htok_pkg::PH_VERSION;
                end
            end
            htok_pkg::PH_VERSION,
            htok_pkg::PH_VALUE:
            begin
                if (data_byte == htok_pkg::CH_CR)
                begin
                    vlen_new = pos_reg - start_reg;
                    ph_new   = (ph == htok_pkg::PH_VERSION) ? htok_pkg::PH_VER_LF
                                                            : htok_pkg::PH_VAL_LF;
                end
            end
            htok_pkg::PH_VER_LF,
            htok_pkg::PH_VAL_LF:
            begin
                if (data_byte != htok_pkg::CH_LF)
                begin
                    if (err_new == htok_pkg::ST_OK)
                        err_new = htok_pkg::ST_MALFORMED;
                    ph_new = htok_pkg::PH_ERROR;
                end
                else
                begin
                    tok.slice_length = 16'(vlen_reg);
                    if (ph == htok_pkg::PH_VER_LF)
                    begin
                        tok_valid      = 1'b1;
                        tok.token_kind = htok_pkg::KIND_VERSION;
                    end
                    else if (room)
                    begin
                        tok_valid         = 1'b1;
                        tok.token_kind    = htok_pkg::KIND_HDR_VALUE;
                        tok.header_number = 5'(hseen_reg);
                        hseen_new         = hseen_reg + HW'(1);
                    end
                    ph_new = htok_pkg::PH_LINE;
                end
            end
            htok_pkg::PH_LINE:
            begin
                if (data_byte == htok_pkg::CH_CR)
                    ph_new = htok_pkg::PH_BLANK_LF;
                else
                begin
                    start_new = pos_reg;
                    if (data_byte == htok_pkg::CH_COLON)
                    begin
                        // empty header name
                        tok_valid         = room;
                        tok.token_kind    = htok_pkg::KIND_HDR_NAME;
                        tok.slice_offset  = 16'(pos_reg);
                        tok.slice_length  = 16'd0;
                        tok.header_number = 5'(hseen_reg);
                        ph_new            = htok_pkg::PH_SKIP;
                    end
                    else
                        ph_new = htok_pkg::PH_NAME;
                end
            end
            htok_pkg::PH_NAME:
            begin
                if (data_byte == htok_pkg::CH_COLON)
                begin
                    tok_valid         = room;
                    tok.token_kind    = htok_pkg::KIND_HDR_NAME;
                    tok.header_number = 5'(hseen_reg);
                    ph_new            = htok_pkg::PH_SKIP;
                end
            end
            htok_pkg::PH_SKIP:
            begin
                if (data_byte != htok_pkg::CH_SPACE)
                begin
                    start_new = pos_reg;
                    if (data_byte == htok_pkg::CH_CR)
                    begin
                        vlen_new = '0;
                        ph_new   = htok_pkg::PH_VAL_LF;
                    end
                    else
                        ph_new = htok_pkg::PH_VALUE;
                end
            end
            htok_pkg::PH_BLANK_LF:
            begin
                if (data_byte == htok_pkg::CH_LF)
                begin
                    start_new = pos_inc;
                    ph_new    = htok_pkg::PH_BODY;
                end
                else
                begin
                    if (err_new == htok_pkg::ST_OK)
                        err_new = htok_pkg::ST_MALFORMED;
                    ph_new = htok_pkg::PH_ERROR;
                end
            end
            default:
            begin
            end
        endcase
    end

    // done item for the final byte of a request
    always_comb
    begin
        done.token_kind    = htok_pkg::KIND_DONE;
        done.slice_offset  = 16'd0;
        done.slice_length  = 16'd0;
        done.header_number = 5'(hseen_new);
        done.parse_status  = err_new;
        done.run_last      = 1'b1;
        if (err_new == htok_pkg::ST_OK)
        begin
            if (ph_new == htok_pkg::PH_LINE)
                done.slice_offset = 16'(pos_inc);
            else if (ph_new == htok_pkg::PH_BODY)
            begin
                done.slice_offset = 16'(start_new);
                done.slice_length = 16'(pos_inc - start_new);
            end
            else
                done.parse_status = htok_pkg::ST_MALFORMED;
        end
    end

    // ordering of the results into the queue
    always_comb
    begin
        push.count  = 2'd0;
        push.first  = done;
        push.second = done;
        if (accept)
        begin
            if (tok_valid)
            begin
                push.first = tok;
                push.count = final_byte ? 2'd2 : 2'd1;
            end
            else if (final_byte)
                push.count = 2'd1;
        end
    end

    // state update, cleared after the final byte
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        vlen_next  = vlen_reg;
        hseen_next = hseen_reg;
        err_next   = err_reg;
        if (accept)
        begin
            if (final_byte)
            begin
                phase_next = htok_pkg::PH_METHOD;
                pos_next   = '0;
                start_next = '0;
                vlen_next  = '0;
                hseen_next = '0;
                err_next   = htok_pkg::ST_OK;
            end
            else
            begin
                phase_next = ph_new;
                pos_next   = pos_max ? pos_reg : pos_inc;
                start_next = start_new;
                vlen_next  = vlen_new;
                hseen_next = hseen_new;
                err_next   = err_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= htok_pkg::PH_METHOD;
            pos_reg   <= '0;
            start_reg <= '0;
            vlen_reg  <= '0;
            hseen_reg <= '0;
            err_reg   <= htok_pkg::ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            vlen_reg  <= vlen_next;
            hseen_reg <= hseen_next;
            err_reg   <= err_next;
        end
    end

endmodule

### design/htok_outq.sv
// small result queue that takes up to two results a cycle and sends one while the sink is ready
module htok_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  htok_pkg::htok_push_t  push,
    output htok_pkg::htok_qstat_t stat,
    htok_out_if.source            tok
);

    localparam int PW = htok_pkg::Q_PTR_BITS;
    localparam int CW = htok_pkg::Q_COUNT_BITS;

    htok_pkg::htok_result_t mem_reg [htok_pkg::Q_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    htok_pkg::htok_result_t head;

    assign head  = mem_reg[rptr_reg];
    assign pop   = tok.valid && tok.ready;
    assign stat.count = count_reg;

    // output beat from the queue head
    assign tok.valid         = (count_reg != '0);
    assign tok.token_kind    = head.token_kind;
    assign tok.slice_offset  = head.slice_offset;
    assign tok.slice_length  = head.slice_length;
    assign tok.header_number = head.header_number;
    assign tok.parse_status  = head.parse_status;
    assign tok.run_last      = head.run_last;

    // pointer and fill level update
    always_comb
    begin
        wptr_next  = wptr_reg + PW'(push.count);
        rptr_next  = rptr_reg + PW'(pop);
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wptr_reg + PW'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### design/http_request_header_tokenizer.sv
// top level: http request line and header tokenizer
// a result is written into the result queue as its byte beat is accepted and leaves from the queue head
// throughput: one byte beat per cycle while input ready is high; a final byte that also ends a token
//   gives two result beats, which leave the result queue in order
// input ready is low while the four-entry result queue lacks room for two results
// reset: rst_n asynchronously clears the parse state and empties the result queue
module http_request_header_tokenizer #(
    parameter int HEADER_LIMIT = htok_pkg::HEADER_LIMIT_DEF,
    parameter int OFFSET_BITS  = htok_pkg::OFFSET_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    htok_in_if.sink    req,
    htok_out_if.source tok
);

    htok_pkg::htok_push_t  push;
    htok_pkg::htok_qstat_t qstat;
    logic                  accept;

    // accept while the queue can take a token and a done result
    assign req.ready = (qstat.count <= htok_pkg::Q_COUNT_BITS'(htok_pkg::Q_DEPTH - 2));
    assign accept    = req.valid && req.ready;

    htok_core #(
        .HEADER_LIMIT (HEADER_LIMIT),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (req.data_byte),
        .final_byte (req.final_byte),
        .push       (push)
    );

    htok_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .stat  (qstat),
        .tok   (tok)
    );

    // queue never overfills
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= htok_pkg::Q_COUNT_BITS'(htok_pkg::Q_DEPTH))
        else $error("result queue overfilled");

    // a final byte always leaves a result pending
    a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.final_byte |=> qstat.count != '0)
        else $error("final byte produced no result");

    // done beats close the results of their byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok.valid && tok.token_kind == htok_pkg::KIND_DONE |-> tok.run_last)
        else $error("done beat without run_last");

    // no push without an accepted byte
    a_push_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> accept)
        else $error("result pushed without a byte beat");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench for the http request header tokenizer: directed requests, then random ones
module testbench;
    import htok_pkg::*;

    localparam int          HDR_LIMIT    = HEADER_LIMIT_DEF;
    localparam int unsigned SCAN_POS_MAX = (1 << OFFSET_BITS_DEF) - 1;
    localparam int          RANDOM_BYTES = 1600;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          PLAN_ROWS    = 24;

    // one directed request: head, repeated header lines, tail, random fill
    typedef struct {
        string        head;
        int unsigned  hdr_lines;
        string        tail;
        int unsigned  fill;
        bit           fixed;
        htok_status_t st;
        int unsigned  off;
        int unsigned  len;
        int unsigned  cnt;
    } plan_row_t;

    logic clk;
    logic rst_n;

    htok_in_if  req_ch ();
    htok_out_if tok_ch ();

    http_request_header_tokenizer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .tok   (tok_ch)
    );

    // directed requests; the done beat is typed in where it is obvious
    plan_row_t plan_rows [PLAN_ROWS] = '{
        '{"GET /index HTTP/1.1\015\012Host: a\015\012\015\012hi", 0, "", 0,
          0, ST_OK, 0, 0, 0},
        '{"GET", 0, "", 0, 1, ST_MALFORMED, 0, 0, 0},
        '{" ", 0, "", 0, 1, ST_MALFORMED, 0, 0, 0},
        '{"GET / H\015\012", 0, "", 0, 1, ST_OK, 9, 0, 0},
        '{"GET / H\015", 0, "", 0, 1, ST_MALFORMED, 0, 0, 0},
        '{"GET / H\015X", 0, "", 0, 1, ST_MALFORMED, 0, 0, 0},
        '{"GET / H\015\012\015X", 0, "", 0, 1, ST_MALFORMED, 0, 0, 0},
        '{"GET / H\015\012A: b\015Z", 0, "", 0, 1, ST_MALFORMED, 0, 0, 0},
        '{"GET / H\015\012A: b\015\012", 0, "", 0, 1, ST_OK, 15, 0, 1},
        '{"GET / H\015\012:   \015\012\015\012", 0, "", 0, 0, ST_OK, 0, 0, 0},
        '{"GET / H\015\012Name", 0, "", 0, 1, ST_MALFORMED, 0, 0, 0},
        '{"GET / H\015\012N: ", 0, "", 0, 1, ST_MALFORMED, 0, 0, 0},
        '{"GET / H\015\012N: v", 0, "", 0, 1, ST_MALFORMED, 0, 0, 0},
        '{"GET / H\015\012\015", 0, "", 0, 1, ST_MALFORMED, 0, 0, 0},
        '{"GET / H\015\012\015\012", 0, "", 0, 1, ST_OK, 11, 0, 0},
        '{"GET / H\015\012", 17, "\015\012body", 0, 1, ST_OK, 113, 4, 16},
        '{"GET / H\015\012", 16, "\015\012", 0, 1, ST_OK, 107, 0, 16},
        '{"GET / H\015\012", 17, "\015Y", 0, 1, ST_MALFORMED, 0, 0, 16},
        '{"\377\177 \001/\376 \200\015\012\015\012\377\001", 0, "", 0,
          0, ST_OK, 0, 0, 0},
        '{"POST /a HTTP/1.0\015\012Key:   v a l\015\012\015\012", 0, "", 0,
          0, ST_OK, 0, 0, 0},
        '{"G:\015 /\015: HTTP\012\015\012\015\012", 0, "", 0, 0, ST_OK, 0, 0, 0},
        '{"GET / H\015\012\015\012", 0, "", 65524, 1, ST_OK, 11, 65524, 0},
        '{"GET / H\015\012\015\012", 0, "", 65528, 1, ST_TOO_LONG, 0, 0, 0},
        '{"A:b c d\015\012x:\015\012\015\012z", 0, "", 0, 0, ST_OK, 0, 0, 0}
    };

    // tokenizer state as predicted
    htok_phase_t  scan_phase;
    int unsigned  scan_pos;
    int unsigned  tok_start;
    int unsigned  held_len;
    int unsigned  hdr_count;
    htok_status_t first_error;

    htok_result_t pending_tokens[$];
    htok_result_t fixed_done;
    bit           fixed_armed;

    logic [7:0]   request_bytes[$];
    bit           src_quiet;
    bit           sink_quiet;
    int unsigned  error_count;
    int unsigned  quiet_cycles;

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic htok_result_t token_beat(htok_kind_t kind, int unsigned off,
                                                int unsigned len, int unsigned num,
                                                htok_status_t st);
        htok_result_t r;
        r.token_kind    = kind;
        r.slice_offset  = off[15:0];
        r.slice_length  = len[15:0];
        r.header_number = num[4:0];
        r.parse_status  = st;
        r.run_last      = 1'b0;
        return r;
    endfunction

    function automatic void clear_scan();
        scan_phase  = PH_METHOD;
        scan_pos    = 0;
        tok_start   = 0;
        held_len    = 0;
        hdr_count   = 0;
        first_error = ST_OK;
    endfunction

    // the first error wins
    function automatic void note_error(htok_status_t code);
        if (first_error == ST_OK)
            first_error = code;
        scan_phase = PH_ERROR;
    endfunction

    // advance the predicted tokenizer by one byte and queue its result beats
    function automatic void tokenize_byte(logic [7:0] c, logic fin);
        int unsigned  p;
        int unsigned  off;
        int unsigned  blen;
        bit           room;
        htok_status_t st;
        htok_result_t done;
        htok_result_t outs[$];
        p    = scan_pos;
        room = hdr_count < HDR_LIMIT;
        if (scan_phase != PH_ERROR && p >= SCAN_POS_MAX)
            note_error(ST_TOO_LONG);

        case (scan_phase)
            PH_METHOD, PH_PATH:
            begin
                if (c == CH_SPACE)
                begin
                    outs.push_back(token_beat(scan_phase == PH_METHOD ? KIND_METHOD : KIND_PATH,
                                              tok_start, p - tok_start, 0, ST_OK));
                    tok_start  = p + 1;
                    scan_phase = (scan_phase == PH_METHOD) ? PH_PATH : PH_VERSION;
                end
            end
            PH_VERSION:
            begin
                if (c == CH_CR)
                begin
                    held_len   = p - tok_start;
                    scan_phase = PH_VER_LF;
                end
            end
            PH_VER_LF, PH_VAL_LF:
            begin
                if (c != CH_LF)
                    note_error(ST_MALFORMED);
                else if (scan_phase == PH_VER_LF)
                begin
                    outs.push_back(token_beat(KIND_VERSION, tok_start, held_len, 0, ST_OK));
                    scan_phase = PH_LINE;
                end
                else
                begin
                    if (room)
                    begin
                        outs.push_back(token_beat(KIND_HDR_VALUE, tok_start, held_len,
                                                  hdr_count, ST_OK));
                        hdr_count++;
                    end
                    scan_phase = PH_LINE;
                end
            end
            PH_LINE:
            begin
                if (c == CH_CR)
                    scan_phase = PH_BLANK_LF;
                else
                begin
                    tok_start = p;
                    if (c == CH_COLON)
                    begin
                        if (room)
                            outs.push_back(token_beat(KIND_HDR_NAME, p, 0, hdr_count, ST_OK));
                        scan_phase = PH_SKIP;
                    end
                    else
                        scan_phase = PH_NAME;
                end
            end
            PH_NAME:
            begin
                if (c == CH_COLON)
                begin
                    if (room)
                        outs.push_back(token_beat(KIND_HDR_NAME, tok_start, p - tok_start,
                                                  hdr_count, ST_OK));
                    scan_phase = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (c != CH_SPACE)
                begin
                    tok_start = p;
                    if (c == CH_CR)
                    begin
                        held_len   = 0;
                        scan_phase = PH_VAL_LF;
                    end
                    else
                        scan_phase = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (c == CH_CR)
                begin
                    held_len   = p - tok_start;
                    scan_phase = PH_VAL_LF;
                end
            end
            PH_BLANK_LF:
            begin
                if (c == CH_LF)
                begin
                    tok_start  = p + 1;
                    scan_phase = PH_BODY;
                end
                else
                    note_error(ST_MALFORMED);
            end
            default:
            begin
            end
        endcase

        if (scan_pos < SCAN_POS_MAX)
            scan_pos++;

        // done beat: status, body slice and header count
        if (fin)
        begin
            st   = first_error;
            off  = 0;
            blen = 0;
            if (st == ST_OK)
            begin
                if (scan_phase == PH_LINE)
                    off = p + 1;
                else if (scan_phase == PH_BODY)
                begin
                    off  = tok_start;
                    blen = p + 1 - tok_start;
                end
                else
                    st = ST_MALFORMED;
            end
            done = token_beat(KIND_DONE, off, blen, hdr_count, st);
            if (fixed_armed)
            begin
                done        = fixed_done;
                fixed_armed = 1'b0;
            end
            outs.push_back(done);
            clear_scan();
        end

        if (outs.size() > 0)
            outs[outs.size() - 1].run_last = 1'b1;
        foreach (outs[i])
            pending_tokens.push_back(outs[i]);
    endfunction

    // byte with a bias toward the delimiters
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return CH_SPACE;
            1: return CH_CR;
            2: return CH_LF;
            3: return CH_COLON;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_raw(int unsigned count);
        repeat (count)
            request_bytes.push_back(pick_byte());
    endfunction

    // token content that avoids the bytes which would end it
    function automatic void add_token(int unsigned count, logic [7:0] stop_a,
                                      logic [7:0] stop_b);
        logic [7:0] b;
        repeat (count)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == stop_a || b == stop_b);
            request_bytes.push_back(b);
        end
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            request_bytes.push_back(s[i]);
    endfunction

    // well-formed request with random content
    function automatic void compose_request();
        int unsigned nhdr;
        int unsigned name_len;
        request_bytes.delete();
        add_token($urandom_range(0, 4), CH_SPACE, CH_SPACE);
        request_bytes.push_back(CH_SPACE);
        add_token($urandom_range(0, 6), CH_SPACE, CH_SPACE);
        request_bytes.push_back(CH_SPACE);
        add_token($urandom_range(0, 6), CH_CR, CH_CR);
        add_text("\015\012");
        nhdr = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 4);
        repeat (nhdr)
        begin
            name_len = $urandom_range(0, 5);
            if (name_len > 0)
            begin
                add_token(1, CH_COLON, CH_CR);
                add_token(name_len - 1, CH_COLON, CH_COLON);
            end
            request_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 3))
                request_bytes.push_back(CH_SPACE);
            add_token($urandom_range(0, 6), CH_CR, CH_CR);
            add_text("\015\012");
        end
        // most requests carry a blank line and a body
        if ($urandom_range(0, 4) != 0)
        begin
            add_text("\015\012");
            add_raw($urandom_range(0, 8));
        end
    endfunction

    task automatic send_beat(logic [7:0] b, logic fin);
        int unsigned pause;
        pause = src_quiet ? 0 : $urandom_range(0, 18);
        if (pause > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (pause) @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.data_byte  = b;
        req_ch.final_byte = fin;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_request();
        for (int k = 0; k < request_bytes.size(); k++)
            send_beat(request_bytes[k], k == request_bytes.size() - 1);
    endtask

    // result sink with random stalls
    initial
    begin
        int unsigned pause;
        tok_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            pause = sink_quiet ? 0 : $urandom_range(0, 18);
            if (pause > 0)
            begin
                tok_ch.ready = 1'b0;
                repeat (pause) @(negedge clk);
            end
            tok_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!tok_ch.valid);
            @(negedge clk);
        end
    end

    // result check, byte prediction and watchdog
    always @(posedge clk)
    begin
        htok_result_t got;
        htok_result_t want;
        if (tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1)
        begin
            got.token_kind    = htok_kind_t'(tok_ch.token_kind);
            got.slice_offset  = tok_ch.slice_offset;
            got.slice_length  = tok_ch.slice_length;
            got.header_number = tok_ch.header_number;
            got.parse_status  = htok_status_t'(tok_ch.parse_status);
            got.run_last      = tok_ch.run_last;
            if (pending_tokens.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat: expected none, actual kind %0d ",
                         $time, got.token_kind,
                         "off %0d len %0d hdr %0d status %0d last %0b",
                         got.slice_offset, got.slice_length, got.header_number,
                         got.parse_status, got.run_last);
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: result mismatch: expected kind %0d off %0d len %0d ",
                             $time, want.token_kind, want.slice_offset, want.slice_length,
                             "hdr %0d status %0d last %0b, actual kind %0d off %0d ",
                             want.header_number, want.parse_status, want.run_last,
                             got.token_kind, got.slice_offset,
                             "len %0d hdr %0d status %0d last %0b",
                             got.slice_length, got.header_number, got.parse_status,
                             got.run_last);
                end
            end
        end

        if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            tokenize_byte(req_ch.data_byte, req_ch.final_byte);

        // nothing accepted for too long
        if ((req_ch.valid && req_ch.ready) || (tok_ch.valid && tok_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int unsigned random_sent;
        int unsigned keep;
        int unsigned pick;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.data_byte  = 8'h00;
        req_ch.final_byte = 1'b0;
        src_quiet         = 1'b0;
        sink_quiet        = 1'b0;
        fixed_armed       = 1'b0;
        error_count       = 0;
        quiet_cycles      = 0;
        random_sent       = 0;
        clear_scan();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed requests
        foreach (plan_rows[r])
        begin
            request_bytes.delete();
            add_text(plan_rows[r].head);
            repeat (plan_rows[r].hdr_lines)
                add_text("h: v\015\012");
            add_text(plan_rows[r].tail);
            repeat (plan_rows[r].fill)
                request_bytes.push_back(8'($urandom_range(0, 255)));
            if (plan_rows[r].fixed)
            begin
                fixed_done  = token_beat(KIND_DONE, plan_rows[r].off, plan_rows[r].len,
                                         plan_rows[r].cnt, plan_rows[r].st);
                fixed_armed = 1'b1;
            end
            src_quiet  = (plan_rows[r].fill > 0) || ($urandom_range(0, 2) == 0);
            sink_quiet = (plan_rows[r].fill > 0) || ($urandom_range(0, 2) == 0);
            send_request();
        end

        // random requests: mostly well-formed, some mutated, cut short or noise
        while (random_sent < RANDOM_BYTES)
        begin
            compose_request();
            pick = $urandom_range(0, 9);
            if (pick == 7)
                request_bytes[$urandom_range(0, request_bytes.size() - 1)] = pick_byte();
            else if (pick == 8)
            begin
                keep = $urandom_range(1, request_bytes.size());
                while (request_bytes.size() > keep)
                    void'(request_bytes.pop_back());
            end
            else if (pick == 9)
            begin
                request_bytes.delete();
                add_raw($urandom_range(1, 12));
            end
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            send_request();
            random_sent += request_bytes.size();
        end
        req_ch.valid = 1'b0;

        // drain the remaining results
        sink_quiet = 1'b1;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
design/htok_pkg.sv
design/htok_in_if.sv
design/htok_out_if.sv
design/htok_core.sv
design/htok_outq.sv
design/http_request_header_tokenizer.sv
tb/testbench.sv
